### rtl/mprm_pkg.sv
package mprm_pkg;

  localparam int CHANNELS   = 8;
  localparam int RING_DEPTH = 16;

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W   = $clog2(RING_DEPTH);
  localparam int ADDR_W  = CH_W + PTR_W;
  localparam int ENTRIES = CHANNELS << PTR_W;

  localparam int STAMP_W = 32;
  localparam int NUM_W   = 16;
  localparam int LIMIT_W = 8;
  localparam int CNT_W   = $clog2(NUM_W);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_NUMERATOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT    = CFG_IDX_W'(1);

  localparam logic CMD_PULSE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [NUM_W-1:0]   RATE_NUMERATOR_RST = NUM_W'(15000);
  localparam logic [LIMIT_W-1:0] STALE_LIMIT_RST    = LIMIT_W'(20);

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [LIMIT_W-1:0] stale_t;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   dividend;
    logic [STAMP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/multichannel_pulse_rate_meter_top.sv
// Eight-channel pulse rate meter. A pulse transfer (tuser = 0) stores its
// timestamp in the channel's 16-entry ring and leaves the input ready. A tick
// transfer (tuser = 1) raises every staleness count below the limit and then
// reports one speed per channel, channel 0 first, tlast on the highest. For each
// channel, S_RD_OLD and S_RD_NEW read the single-port timestamp RAM, S_SPAN forms
// the span, the shared restoring divider runs 16 steps and raises a registered
// done flag, and S_OUT holds the registered speed through any output stall; the
// input is not ready until the last speed has been transferred. Stale or zero
// spans skip the divider. Timestamp entries never written read as zero.
module multichannel_pulse_rate_meter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // channel [2:0], timestamp [34:3], zero fill
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // channel_out [2:0], speed [18:3], zero fill
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mprm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_RD_OLD,
    S_RD_NEW,
    S_SPAN,
    S_DIV,
    S_OUT
  } state_t;

  state_t               state_r;
  logic [NUM_W-1:0]     rate_num_r;
  stale_t               stale_limit_r;
  ptr_t                 ptr_r   [CHANNELS];
  stale_t               stale_r [CHANNELS];
  logic [ENTRIES-1:0]   vld_r;
  logic                 vld_rd_r;
  logic [CH_W-1:0]      ch_r;
  logic [STAMP_W-1:0]   oldest_r;
  logic                 out_valid_r;
  logic [2:0]           out_ch_r;
  logic [NUM_W-1:0]     out_speed_r;
  logic                 out_last_r;

  logic                 in_xfer;
  logic                 out_xfer;
  logic [2:0]           in_channel;
  logic [STAMP_W-1:0]   in_stamp;
  logic [CH_W-1:0]      in_ch;
  logic                 in_ch_ok;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [STAMP_W-1:0]   ram_rdata;
  logic [STAMP_W-1:0]   rd_stamp;
  ptr_t                 newest_slot;
  logic [STAMP_W-1:0]   span;
  logic                 stale_now;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = out_valid_r && out_tready;
  assign in_channel = in_tdata[2:0];
  assign in_stamp   = in_tdata[34:3];
  assign in_ch      = CH_W'(in_channel);
  assign in_ch_ok   = 32'(in_channel) < 32'(CHANNELS);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_speed_r, out_ch_r};
  assign out_tlast  = out_last_r;

  always_comb begin
    newest_slot = (ptr_r[ch_r] == '0) ? PTR_W'(RING_DEPTH - 1) : ptr_r[ch_r] - PTR_W'(1);
    rd_stamp    = vld_rd_r ? ram_rdata : '0;
    span        = rd_stamp - oldest_r;
    stale_now   = stale_r[ch_r] >= stale_limit_r;
    ram_we      = in_xfer && (in_tuser == CMD_PULSE) && in_ch_ok;
    if (state_r == S_IDLE) begin
      ram_addr = {in_ch, ptr_r[in_ch]};
    end else if (state_r == S_RD_NEW) begin
      ram_addr = {ch_r, newest_slot};
    end else begin
      ram_addr = {ch_r, ptr_r[ch_r]};
    end
    div_req.start    = (state_r == S_SPAN) && !stale_now && (span != '0);
    div_req.dividend = rate_num_r;
    div_req.divisor  = span;
  end

  mprm_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (ENTRIES)
  ) u_times (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_stamp),
    .rdata (ram_rdata)
  );

  mprm_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rate_num_r    <= RATE_NUMERATOR_RST;
      stale_limit_r <= STALE_LIMIT_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        ptr_r[i]   <= '0;
        stale_r[i] <= '0;
      end
      vld_r       <= '0;
      vld_rd_r    <= 1'b0;
      ch_r        <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
      out_ch_r    <= '0;
      out_speed_r <= '0;
      out_last_r  <= 1'b0;
    end else begin
      vld_rd_r <= vld_r[ram_addr];

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_RATE_NUMERATOR) begin
          rate_num_r <= cfg_data;
        end else if (cfg_index == REG_STALE_LIMIT) begin
          stale_limit_r <= cfg_data[LIMIT_W-1:0];
        end
      end

      if (out_xfer) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_tuser == CMD_TICK) begin
              state_r <= S_TICK;
            end else if (in_ch_ok) begin
              vld_r[ram_addr] <= 1'b1;
              ptr_r[in_ch]    <= (ptr_r[in_ch] == PTR_W'(RING_DEPTH - 1)) ?
                                 '0 : ptr_r[in_ch] + PTR_W'(1);
              stale_r[in_ch]  <= '0;
            end
          end
        end
        S_TICK: begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (stale_r[i] < stale_limit_r) begin
              stale_r[i] <= stale_r[i] + LIMIT_W'(1);
            end
          end
          ch_r    <= '0;
          state_r <= S_RD_OLD;
        end
        S_RD_OLD: begin
          state_r <= S_RD_NEW;
        end
        S_RD_NEW: begin
          oldest_r <= rd_stamp;
          state_r  <= S_SPAN;
        end
        S_SPAN: begin
          out_ch_r   <= 3'(ch_r);
          out_last_r <= (32'(ch_r) == 32'(CHANNELS - 1));
          if (div_req.start) begin
            state_r <= S_DIV;
          end else begin
            out_speed_r <= '0;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            out_speed_r <= div_rsp.quotient;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the speed is transferred
          if (out_xfer) begin
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              ch_r    <= ch_r + CH_W'(1);
              state_r <= S_RD_OLD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/mprm_ram.sv
module mprm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/mprm_divider.sv
module mprm_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  mprm_pkg::div_req_t req,
  output mprm_pkg::div_rsp_t rsp
);
  import mprm_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [NUM_W-1:0]     rem_r;
  logic [NUM_W-1:0]     quo_r;
  logic [STAMP_W-1:0]   dsr_r;
  logic [NUM_W:0]       rem_shift;
  logic                 fits;

  // partial remainder never exceeds a prefix of the 16-bit dividend
  always_comb begin
    rem_shift = {rem_r, quo_r[NUM_W-1]};
    fits      = STAMP_W'(rem_shift) >= dsr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      quo_r  <= '0;
      dsr_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= NUM_W'(STAMP_W'(rem_shift) - dsr_r);
          quo_r <= {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_shift[NUM_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### bench/multichannel_pulse_rate_meter_top_tb.sv
module multichannel_pulse_rate_meter_top_tb;
  import mprm_pkg::*;

  localparam int LONG_STALL    = 600;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic               cmd;
    logic [CH_W-1:0]    chan;
    logic [STAMP_W-1:0] stamp;
  } meter_item_t;

  typedef struct {
    logic [CH_W-1:0]  chan;
    logic [NUM_W-1:0] speed;
    logic             last;
  } speed_rec_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [39:0]           in_tdata   = '0;  // channel [2:0], timestamp [34:3], zero fill
  logic                  in_tuser   = 1'b0;  // command
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;  // channel_out [2:0], speed [18:3], zero fill
  logic                  out_tlast;  // last
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  meter_item_t pending_items[$];
  speed_rec_t  speed_expect[$];

  // shadow copy of the meter state and its registers
  logic [STAMP_W-1:0] stamp_ring [CHANNELS][RING_DEPTH];
  ptr_t               ring_ptr   [CHANNELS];
  stale_t             stale_cnt  [CHANNELS];
  logic [NUM_W-1:0]   numer;
  stale_t             stale_lim;

  // per-channel running pulse clock for well-formed trains
  logic [STAMP_W-1:0] train_time [CHANNELS];

  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  int stall_requests = 0;
  int stall_served   = 0;
  int hold_left      = 0;
  int errors         = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int cfg_writes     = 0;

  multichannel_pulse_rate_meter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic predict_speeds(input logic cmd, input logic [CH_W-1:0] chan,
                                input logic [STAMP_W-1:0] stamp);
    ptr_t               oldest;
    ptr_t               newest;
    logic [STAMP_W-1:0] span;
    speed_rec_t         rec;
    if (cmd == CMD_PULSE) begin
      stamp_ring[chan][ring_ptr[chan]] = stamp;
      ring_ptr[chan] = ring_ptr[chan] + PTR_W'(1);
      stale_cnt[chan] = '0;
    end else begin
      for (int ch = 0; ch < CHANNELS; ch++)
        if (stale_cnt[ch] < stale_lim) stale_cnt[ch] = stale_cnt[ch] + LIMIT_W'(1);
      for (int ch = 0; ch < CHANNELS; ch++) begin
        oldest = ring_ptr[ch];
        newest = oldest - PTR_W'(1);
        span = stamp_ring[ch][newest] - stamp_ring[ch][oldest];
        rec.chan = CH_W'(ch);
        rec.last = (ch == CHANNELS - 1);
        if (stale_cnt[ch] >= stale_lim || span == '0) rec.speed = '0;
        else rec.speed = NUM_W'(STAMP_W'(numer) / span);
        speed_expect.push_back(rec);
      end
    end
  endtask

  task automatic queue_item(input logic cmd, input int chan, input logic [STAMP_W-1:0] stamp);
    meter_item_t it;
    it.cmd = cmd;
    it.chan = CH_W'(chan);
    it.stamp = stamp;
    pending_items.push_back(it);
  endtask

  // mostly pulse trains with random gaps, some ticks, some pulses at random times
  task automatic queue_random(input int count, input int max_gap, input int tick_pct);
    int roll;
    int ch;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      ch = $urandom_range(CHANNELS - 1);
      if (roll < tick_pct) begin
        queue_item(CMD_TICK, ch, $urandom);
      end else if (roll < tick_pct + 8) begin
        queue_item(CMD_PULSE, ch, $urandom);
      end else begin
        train_time[ch] = train_time[ch] + $urandom_range(max_gap, 1);
        queue_item(CMD_PULSE, ch, train_time[ch]);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_RATE_NUMERATOR) numer = data;
    else if (idx == REG_STALE_LIMIT) stale_lim = data[LIMIT_W-1:0];
    cfg_writes++;
  endtask

  // check at the falling edge so all updates of the rising edge have landed
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || speed_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    meter_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_speeds(in_tuser, in_tdata[2:0], in_tdata[34:3]);
        items_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          it = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= it.cmd;
          in_tdata  <= {5'b0, it.stamp, it.chan};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with an occasional long hold-off
  always @(posedge clk) begin
    if (stall_served != stall_requests) begin
      stall_served <= stall_requests;
      hold_left    <= LONG_STALL;
      out_tready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    speed_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (speed_expect.size() == 0) begin
        $error("speed transfer for channel %0d with nothing expected", out_tdata[2:0]);
        errors++;
      end else begin
        want = speed_expect.pop_front();
        if (out_tdata[2:0] !== want.chan) begin
          $error("channel_out: expected %0d, got %0d", want.chan, out_tdata[2:0]);
          errors++;
        end
        if (out_tdata[18:3] !== want.speed) begin
          $error("speed: expected %0d, got %0d", want.speed, out_tdata[18:3]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      ring_ptr[ch] = '0;
      stale_cnt[ch] = '0;
      for (int s = 0; s < RING_DEPTH; s++) stamp_ring[ch][s] = '0;
      // even channels start just below the wrap of the millisecond clock
      if (ch % 2 == 0) train_time[ch] = 32'hFFFF_FFFF - $urandom_range(400);
      else train_time[ch] = $urandom;
    end
    numer = RATE_NUMERATOR_RST;
    stale_lim = STALE_LIMIT_RST;
    tx_idle_pct <= 12;
    rx_idle_pct <= 79;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // zero spans out of reset, lone first entries, extreme stamps
    @(negedge clk);
    queue_item(CMD_TICK, 7, 32'hFFFF_FFFF);
    queue_item(CMD_PULSE, 0, 32'hFFFF_FFFF);
    queue_item(CMD_PULSE, 7, 32'h0000_0001);
    queue_item(CMD_PULSE, 3, 32'h8000_0000);
    queue_item(CMD_PULSE, 5, 32'h0000_0000);
    queue_item(CMD_TICK, 0, 32'h0000_0000);
    wait_idle();

    // full numerator over a span of one, then channels going stale
    write_reg(REG_RATE_NUMERATOR, 16'hFFFF);
    write_reg(REG_STALE_LIMIT, 16'd2);
    @(negedge clk);
    queue_item(CMD_PULSE, 4, 32'h0000_0001);
    queue_item(CMD_PULSE, 6, 32'h0000_0003);
    queue_item(CMD_TICK, 2, 32'h5555_5555);
    queue_item(CMD_TICK, 5, 32'hAAAA_AAAA);
    queue_item(CMD_TICK, 1, 32'h0000_0000);
    wait_idle();

    // unknown indexes are dropped; the limit keeps only its low byte, here zero
    write_reg(8'd2, 16'h1234);
    write_reg(8'hFF, 16'hFFFF);
    write_reg(REG_STALE_LIMIT, 16'hFF00);
    write_reg(REG_RATE_NUMERATOR, 16'd0);
    @(negedge clk);
    queue_item(CMD_PULSE, 6, 32'h0000_0004);
    queue_item(CMD_TICK, 3, 32'h0F0F_0F0F);
    wait_idle();

    // back to reset settings; hold the receiver so the input backs up
    write_reg(REG_RATE_NUMERATOR, RATE_NUMERATOR_RST);
    write_reg(REG_STALE_LIMIT, CFG_DATA_W'(STALE_LIMIT_RST));
    @(negedge clk);
    queue_random(70, 40, 25);
    stall_requests <= stall_requests + 1;
    wait_idle();

    tx_idle_pct <= 79;
    rx_idle_pct <= 12;
    write_reg(REG_RATE_NUMERATOR, CFG_DATA_W'($urandom_range(65535, 1)));
    write_reg(REG_STALE_LIMIT, 16'd3);
    @(negedge clk);
    queue_random(70, 4, 25);
    wait_idle();

    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    write_reg(REG_RATE_NUMERATOR, 16'hFFFF);
    write_reg(REG_STALE_LIMIT, 16'h00FF);
    @(negedge clk);
    queue_random(60, 2000, 20);
    wait_idle();

    write_reg(REG_RATE_NUMERATOR, 16'd1);
    write_reg(REG_STALE_LIMIT, 16'd1);
    @(negedge clk);
    queue_random(25, 40, 30);
    wait_idle();

    write_reg(REG_RATE_NUMERATOR, CFG_DATA_W'($urandom_range(65535, 1)));
    write_reg(REG_STALE_LIMIT, CFG_DATA_W'($urandom_range(12, 2)));
    @(negedge clk);
    queue_random(40, 60, 25);
    wait_idle();

    $display("Sent %0d pulse and tick transfers across %0d register writes",
             items_sent, cfg_writes);
    $display("Checked %0d channel speeds, including stale, zero-span and wrapped spans",
             results_seen);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/mprm_pkg.sv
rtl/mprm_ram.sv
rtl/mprm_divider.sv
rtl/multichannel_pulse_rate_meter_top.sv
bench/multichannel_pulse_rate_meter_top_tb.sv
